@@ rtl/stt_pkg.sv @@
package stt_pkg;

    localparam int TYPE_W  = 6;
    localparam int OUT_W   = 16;
    localparam int NUM_KW  = 17;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [TYPE_W-1:0] T_DEQ     = 6'd11;
    localparam logic [TYPE_W-1:0] T_EQ      = 6'd12;
    localparam logic [TYPE_W-1:0] T_INVALID = 6'd20;
    localparam logic [TYPE_W-1:0] T_STRING  = 6'd21;
    localparam logic [TYPE_W-1:0] T_SLASH   = 6'd27;
    localparam logic [TYPE_W-1:0] T_KW0     = 6'd32;
    localparam logic [TYPE_W-1:0] T_IDENT   = 6'd49;
    localparam logic [TYPE_W-1:0] T_FLOAT   = 6'd50;
    localparam logic [TYPE_W-1:0] T_INT     = 6'd51;
    localparam logic [TYPE_W-1:0] T_UNKNOWN = 6'd52;
    localparam logic [TYPE_W-1:0] T_END     = 6'd54;

    // keywords padded to six characters with NUL, first character in the top byte
    localparam logic [47:0] KW_STR [NUM_KW] = '{
        "if\000\000\000\000", "else\000\000", "for\000\000\000", "while\000",
        "return", "class\000", "let\000\000\000", "fn\000\000\000\000",
        "i8\000\000\000\000", "i16\000\000\000", "i32\000\000\000",
        "i64\000\000\000", "u8\000\000\000\000", "u16\000\000\000",
        "u32\000\000\000", "u64\000\000\000", "bool\000\000"
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd5, 3'd3, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4
    };

    typedef struct packed {
        logic [TYPE_W-1:0] ttype;
        logic [OUT_W-1:0]  start;
        logic [OUT_W-1:0]  len;
        logic              fin;
    } token_t;

    typedef struct packed {
        logic [1:0]       cnt;
        token_t [2:0]     tok;
    } bundle_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
               c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // single punctuation code, UNKNOWN for anything else
    function automatic logic [TYPE_W-1:0] punct_code(input logic [7:0] c);
        logic [TYPE_W-1:0] t;
        case (c)
            "!":   t = 6'd0;
            "@":   t = 6'd1;
            "#":   t = 6'd2;
            "%":   t = 6'd3;
            "^":   t = 6'd4;
            "&":   t = 6'd5;
            "*":   t = 6'd6;
            "(":   t = 6'd7;
            ")":   t = 6'd8;
            "-":   t = 6'd9;
            "+":   t = 6'd10;
            "[":   t = 6'd13;
            "]":   t = 6'd14;
            "{":   t = 6'd15;
            "}":   t = 6'd16;
            ":":   t = 6'd17;
            ";":   t = 6'd18;
            8'h27: t = 6'd19;
            8'h5C: t = 6'd22;
            "|":   t = 6'd23;
            ",":   t = 6'd24;
            ".":   t = 6'd25;
            "?":   t = 6'd26;
            "<":   t = 6'd28;
            ">":   t = 6'd29;
            8'h60: t = 6'd30;
            "~":   t = 6'd31;
            default: t = T_UNKNOWN;
        endcase
        return t;
    endfunction

    // keep keywords whose character at idx equals c; idx 6 or 7 means past every keyword
    function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] mask,
                                                    input logic [2:0] idx,
                                                    input logic [7:0] c);
        logic [NUM_KW-1:0] res;
        res = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (mask[k] && idx < 3'd6 && KW_STR[k][8*(5-int'(idx)) +: 8] == c) begin
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/stt_front.sv @@
module stt_front import stt_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         accept,
    input  logic [7:0]   ch,
    input  logic         text_end,
    output logic         push,
    output bundle_t      bundle
);

    typedef enum logic [2:0] {
        M_IDLE, M_SLASH, M_EQ, M_STRING, M_IDENT, M_NUMBER, M_LINE, M_BLOCK
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_TWO = POSITION_BITS'(2);

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] len_reg, len_next;
    logic                     dot_reg, dot_next;
    logic [NUM_KW-1:0]        kw_reg, kw_next;
    logic                     star_reg, star_next;

    token_t [2:0] tok;
    logic [1:0]   cnt;
    logic         do_pend, do_fresh, word_ch;
    logic [2:0]   kw_idx;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] x);
        return (x == POS_MAX) ? x : x + POS_ONE;
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [POSITION_BITS-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return w[OUT_W-1:0];
    endfunction

    function automatic token_t mk(input logic [TYPE_W-1:0] t,
                                  input logic [POSITION_BITS-1:0] s,
                                  input logic [POSITION_BITS-1:0] l,
                                  input logic f);
        token_t r;
        r.ttype = t;
        r.start = to_out(s);
        r.len   = to_out(l);
        r.fin   = f;
        return r;
    endfunction

    // true when mode m holds an unfinished token
    function automatic logic has_pending(input mode_t m);
        return m == M_SLASH || m == M_EQ || m == M_STRING || m == M_IDENT ||
               m == M_NUMBER;
    endfunction

    function automatic token_t pending_tok(input mode_t m,
                                           input logic [POSITION_BITS-1:0] s,
                                           input logic [POSITION_BITS-1:0] l,
                                           input logic d,
                                           input logic [NUM_KW-1:0] kw);
        logic [TYPE_W-1:0] t;
        token_t r;
        t = T_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if (kw[k] && l == POSITION_BITS'(KW_LEN[k])) begin
                t = T_KW0 + TYPE_W'(k);
            end
        end
        unique case (m)
            M_SLASH:  r = mk(T_SLASH, s, POS_ONE, 1'b0);
            M_EQ:     r = mk(T_EQ, s, POS_ONE, 1'b0);
            M_STRING: r = mk(T_INVALID, s, l, 1'b0);
            M_IDENT:  r = mk(t, s, l, 1'b0);
            M_NUMBER: r = mk(d ? T_FLOAT : T_INT, s, l, 1'b0);
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign word_ch = is_letter(ch) || is_digit(ch) || ch == "_";
    assign kw_idx  = (len_reg > POSITION_BITS'(7)) ? 3'd7 : len_reg[2:0];

    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        dot_next   = dot_reg;
        kw_next    = kw_reg;
        star_next  = star_reg;
        tok        = '0;
        cnt        = 2'd0;
        do_pend    = 1'b0;
        do_fresh   = 1'b0;

        unique case (mode_reg)
            M_SLASH: begin
                if (ch == "/") begin
                    mode_next = M_LINE;
                end else if (ch == "*") begin
                    mode_next = M_BLOCK;
                    star_next = 1'b0;
                end else begin
                    do_pend  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            M_EQ: begin
                if (ch == "=") begin
                    tok[cnt]  = mk(T_DEQ, start_reg, POS_TWO, 1'b0);
                    cnt       = cnt + 2'd1;
                    mode_next = M_IDLE;
                end else begin
                    do_pend  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            M_STRING: begin
                len_next = sat_inc(len_reg);
                if (ch == 8'h22) begin
                    tok[cnt]  = mk(T_STRING, start_reg, len_next, 1'b0);
                    cnt       = cnt + 2'd1;
                    mode_next = M_IDLE;
                end
            end
            M_IDENT: begin
                if (word_ch) begin
                    kw_next  = kw_filter(kw_reg, kw_idx, ch);
                    len_next = sat_inc(len_reg);
                end else begin
                    do_pend  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_digit(ch) || ch == ".") begin
                    if (ch == ".") begin
                        dot_next = 1'b1;
                    end
                    len_next = sat_inc(len_reg);
                end else begin
                    do_pend  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            M_LINE: begin
                if (ch == 8'h0A) begin
                    mode_next = M_IDLE;
                end
            end
            M_BLOCK: begin
                if (star_reg && ch == "/") begin
                    mode_next = M_IDLE;
                end
                star_next = (ch == "*");
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase

        if (do_pend) begin
            tok[cnt] = pending_tok(mode_reg, start_reg, len_reg, dot_reg, kw_reg);
            cnt      = cnt + 2'd1;
        end

        if (do_fresh) begin
            mode_next  = M_IDLE;
            start_next = pos_reg;
            len_next   = POS_ONE;
            if (is_space(ch)) begin
                mode_next = M_IDLE;
            end else if (ch == "/") begin
                mode_next = M_SLASH;
            end else if (ch == "=") begin
                mode_next = M_EQ;
            end else if (ch == 8'h22) begin
                mode_next = M_STRING;
            end else if (is_letter(ch) || ch == "_") begin
                mode_next = M_IDENT;
                kw_next   = kw_filter({NUM_KW{1'b1}}, 3'd0, ch);
            end else if (is_digit(ch)) begin
                mode_next = M_NUMBER;
                dot_next  = 1'b0;
            end else begin
                tok[cnt] = mk(punct_code(ch), pos_reg, POS_ONE, 1'b0);
                cnt      = cnt + 2'd1;
            end
        end

        pos_next = sat_inc(pos_reg);

        if (text_end) begin
            if (has_pending(mode_next)) begin
                tok[cnt] = pending_tok(mode_next, start_next, len_next, dot_next, kw_next);
                cnt      = cnt + 2'd1;
            end
            tok[cnt]   = mk(T_END, pos_next, '0, 1'b1);
            cnt        = cnt + 2'd1;
            mode_next  = M_IDLE;
            start_next = '0;
            pos_next   = '0;
            len_next   = '0;
            dot_next   = 1'b0;
            kw_next    = '0;
            star_next  = 1'b0;
        end
    end

    assign push       = accept && (cnt != 2'd0);
    assign bundle.cnt = cnt;
    assign bundle.tok = tok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            dot_reg   <= 1'b0;
            kw_reg    <= '0;
            star_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            dot_reg   <= dot_next;
            kw_reg    <= kw_next;
            star_reg  <= star_next;
        end
    end

endmodule

@@ rtl/stt_queue.sv @@
module stt_queue import stt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  bundle_t  wr_data,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output bundle_t  head
);

    bundle_t           mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_reg, rd_reg;
    logic [Q_AW:0]     count_reg;

    assign full      = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + Q_AW'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + Q_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (Q_AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (Q_AW+1)'(1);
            end
        end
    end

endmodule

@@ rtl/stt_back.sv @@
module stt_back import stt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    input  bundle_t  q_head,
    output logic     q_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output token_t   m_tok
);

    logic       valid_reg;
    token_t     tok_reg;
    logic [1:0] sub_reg;
    logic       load, last_sub;

    assign load     = !valid_reg || m_ready;
    assign last_sub = (sub_reg == q_head.cnt - 2'd1);
    assign q_pop    = load && q_valid && last_sub;
    assign m_valid  = valid_reg;
    assign m_tok    = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sub_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= q_valid;
            if (q_valid) begin
                sub_reg <= last_sub ? 2'd0 : sub_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && q_valid) begin
            tok_reg <= q_head.tok[sub_reg];
        end
    end

endmodule

@@ rtl/source_text_tokenizer.sv @@
// Streaming tokenizer for source text.
// Input stream (s_): one byte of text per request in s_tdata, s_tlast on the
//   final byte of a text. Senders must not send a zero byte; it is unchecked.
// Output stream (m_): one token per request: type, start offset and length
//   in m_tdata, m_tlast set on the END token that closes each text.
// Each byte yields zero to three tokens; whitespace and comments yield none.
// A byte is classified in the front stage in the cycle it is taken; its
// tokens go into a four-entry queue and the back stage hands them out one
// per unstalled cycle through an output register.
// A byte's tokens pass through the queue and the output register to m_.
// Throughput: one byte per cycle while the queue has room; the output side
//   drains one token per unstalled cycle, so bytes that raise several tokens
//   (pending token, punctuation and END) slow intake only when the queue fills.
// Stalls: when m_tready is low the output holds its token, the queue fills
//   and s_tready drops once all four entries are taken.
// Reset (aresetn low, synchronous): lexer back to idle at offset zero, queue
//   and output emptied. After each END the lexer returns to that state too.
// Offsets and lengths saturate at 2^POSITION_BITS - 1.
module source_text_tokenizer import stt_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // text_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [5:0] token_type, [21:6] token_start,
                                   // [37:22] token_length, [39:38] zero
    output logic        m_tlast    // final_token
);

    logic    accept, push, q_full, q_valid, q_pop;
    bundle_t bundle, q_head;
    token_t  out_tok;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // front: lexer state and classification of each byte
    stt_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .ch       (s_tdata),
        .text_end (s_tlast),
        .push     (push),
        .bundle   (bundle)
    );

    // decoupling queue of per-byte token groups
    stt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_data   (bundle),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // back: serialize tokens onto the output register
    stt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_tok   (out_tok)
    );

    assign m_tdata = {2'b00, out_tok.len, out_tok.start, out_tok.ttype};
    assign m_tlast = out_tok.fin;

endmodule

@@ tb/sv/tok_checker.sv @@
`timescale 1ns / 1ps
module tok_checker import stt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_tokens,
    output int          tokens_seen
);
    typedef enum logic [2:0] {
        LX_IDLE, LX_SLASH, LX_EQ, LX_STRING, LX_IDENT, LX_NUMBER, LX_LINE, LX_BLOCK
    } lex_mode_t;

    localparam logic [15:0] POS_SAT = 16'hFFFF;
    localparam string KW_NAMES [NUM_KW] = '{
        "if", "else", "for", "while", "return", "class", "let", "fn",
        "i8", "i16", "i32", "i64", "u8", "u16", "u32", "u64", "bool"
    };

    lex_mode_t         mode;
    logic [15:0]       tok_start, text_pos, tok_len;
    logic              dot_seen, star_seen;
    logic [NUM_KW-1:0] kw_live;
    token_t            token_q [$];

    function automatic logic [15:0] sat1(input logic [15:0] x);
        return (x == POS_SAT) ? x : x + 16'd1;
    endfunction

    function automatic logic sp(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction
    function automatic logic letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction
    function automatic logic digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [TYPE_W-1:0] single_char(input logic [7:0] c);
        string punct;
        punct = "!@#%^&*()-+";
        for (int i = 0; i < punct.len(); i++)
            if (punct[i] == c) return TYPE_W'(i);
        case (c)
            "[": return 6'd13;  "]": return 6'd14;  "{": return 6'd15;  "}": return 6'd16;
            ":": return 6'd17;  ";": return 6'd18;  8'h27: return 6'd19; 8'h5C: return 6'd22;
            "|": return 6'd23;  ",": return 6'd24;  ".": return 6'd25;  "?": return 6'd26;
            "<": return 6'd28;  ">": return 6'd29;  8'h60: return 6'd30; "~": return 6'd31;
            default: return T_UNKNOWN;
        endcase
    endfunction

    // keywords still matching after char c at index idx
    function automatic logic [NUM_KW-1:0] narrow_kw(input logic [NUM_KW-1:0] m,
                                                    input logic [15:0] idx,
                                                    input logic [7:0] c);
        logic [NUM_KW-1:0] r;
        r = '0;
        for (int k = 0; k < NUM_KW; k++)
            if (m[k] && idx < KW_NAMES[k].len() && KW_NAMES[k][idx] == c) r[k] = 1'b1;
        return r;
    endfunction

    function automatic token_t mk(input logic [TYPE_W-1:0] t, input logic [15:0] s,
                                  input logic [15:0] l, input logic f);
        token_t x;
        x.ttype = t; x.start = s; x.len = l; x.fin = f;
        return x;
    endfunction

    // append one expected token
    task automatic add_token(input token_t x);
        token_q = {token_q, x};
    endtask

    task automatic flush_pending();
        logic [TYPE_W-1:0] t;
        case (mode)
            LX_SLASH:  add_token(mk(T_SLASH, tok_start, 16'd1, 1'b0));
            LX_EQ:     add_token(mk(T_EQ, tok_start, 16'd1, 1'b0));
            LX_STRING: add_token(mk(T_INVALID, tok_start, tok_len, 1'b0));
            LX_IDENT: begin
                t = T_IDENT;
                for (int k = 0; k < NUM_KW; k++)
                    if (kw_live[k] && tok_len == KW_NAMES[k].len()) t = T_KW0 + TYPE_W'(k);
                add_token(mk(t, tok_start, tok_len, 1'b0));
            end
            LX_NUMBER: add_token(mk(dot_seen ? T_FLOAT : T_INT, tok_start,
                                    tok_len, 1'b0));
            default: ;
        endcase
        mode = LX_IDLE;
    endtask

    task automatic begin_token(input logic [7:0] c, input logic [15:0] p);
        tok_start = p;
        tok_len = 16'd1;
        if (sp(c)) return;
        if (c == "/") mode = LX_SLASH;
        else if (c == "=") mode = LX_EQ;
        else if (c == 8'h22) mode = LX_STRING;
        else if (letter(c) || c == "_") begin
            mode = LX_IDENT;
            kw_live = narrow_kw('1, 16'd0, c);
        end else if (digit(c)) begin
            mode = LX_NUMBER;
            dot_seen = 1'b0;
        end else add_token(mk(single_char(c), p, 16'd1, 1'b0));
    endtask

    task automatic clear_lexer();
        mode = LX_IDLE; tok_start = '0; text_pos = '0; dot_seen = 1'b0;
        kw_live = '0; star_seen = 1'b0; tok_len = '0;
    endtask

    // one accepted byte: advance lexer, queue the tokens it produces
    task automatic lex_byte(input logic [7:0] c, input logic last);
        logic [15:0] p;
        p = text_pos;
        case (mode)
            LX_SLASH:
                if (c == "/") mode = LX_LINE;
                else if (c == "*") begin mode = LX_BLOCK; star_seen = 1'b0; end
                else begin flush_pending(); begin_token(c, p); end
            LX_EQ:
                if (c == "=") begin
                    add_token(mk(T_DEQ, tok_start, 16'd2, 1'b0));
                    mode = LX_IDLE;
                end else begin flush_pending(); begin_token(c, p); end
            LX_STRING: begin
                tok_len = sat1(tok_len);
                if (c == 8'h22) begin
                    add_token(mk(T_STRING, tok_start, tok_len, 1'b0));
                    mode = LX_IDLE;
                end
            end
            LX_IDENT:
                if (letter(c) || digit(c) || c == "_") begin
                    kw_live = narrow_kw(kw_live, tok_len, c);
                    tok_len = sat1(tok_len);
                end else begin flush_pending(); begin_token(c, p); end
            LX_NUMBER:
                if (digit(c) || c == ".") begin
                    if (c == ".") dot_seen = 1'b1;
                    tok_len = sat1(tok_len);
                end else begin flush_pending(); begin_token(c, p); end
            LX_LINE:  if (c == 8'h0A) mode = LX_IDLE;
            LX_BLOCK: begin
                if (star_seen && c == "/") mode = LX_IDLE;
                star_seen = (c == "*");
            end
            default: begin_token(c, p);
        endcase
        text_pos = sat1(p);
        if (last) begin
            flush_pending();
            add_token(mk(T_END, text_pos, 16'd0, 1'b1));
            clear_lexer();
        end
    endtask

    always @(posedge aclk) begin
        token_t want;
        if (!aresetn) begin
            clear_lexer();
            token_q.delete();
            fail_count <= 0;
            tokens_seen <= 0;
        end else begin
            if (s_tvalid && s_tready) lex_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                tokens_seen <= tokens_seen + 1;
                if (token_q.size() == 0) begin
                    $error("unexpected token %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = token_q.pop_front();
                    if (m_tdata[5:0] !== want.ttype ||
                        m_tdata[21:6] !== want.start ||
                        m_tdata[37:22] !== want.len ||
                        m_tdata[39:38] !== 2'b00 ||
                        m_tlast !== want.fin) begin
                        fail_count <= fail_count + 1;
                        if (m_tdata[5:0] !== want.ttype)
                            $error("token_type exp %0d got %0d", want.ttype, m_tdata[5:0]);
                        if (m_tdata[21:6] !== want.start)
                            $error("token_start exp %0d got %0d", want.start, m_tdata[21:6]);
                        if (m_tdata[37:22] !== want.len)
                            $error("token_length exp %0d got %0d", want.len,
                                   m_tdata[37:22]);
                        if (m_tdata[39:38] !== 2'b00)
                            $error("tdata pad exp 0 got %b", m_tdata[39:38]);
                        if (m_tlast !== want.fin)
                            $error("final_token exp %b got %b", want.fin, m_tlast);
                    end
                end
            end
        end
        pending_tokens <= token_q.size();
    end
endmodule

@@ tb/sv/tb_source_text_tokenizer.sv @@
`timescale 1ns / 1ps
module tb_source_text_tokenizer;

    localparam int CYCLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h20;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int fail_count, pending_tokens, tokens_seen;
    int bytes_sent = 0;
    int texts_sent = 0;
    int cycle_count = 0;
    int src_idle_pct = 27;   // sender gap chance, percent
    int snk_idle_pct = 66;   // receiver stall chance, percent
    logic hold_sink = 1'b0;  // long receiver hold-off

    always #1 aclk = ~aclk;

    source_text_tokenizer u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

    tok_checker u_chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .fail_count, .pending_tokens, .tokens_seen
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("source_text_tokenizer regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, or held off completely
    always @(negedge aclk)
        m_tready <= aresetn && !hold_sink && ($urandom_range(99) >= snk_idle_pct);

    // one byte through the handshake, with optional random gap first;
    // valid stays up afterwards so back-to-back bytes need no gap
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
        if (last) texts_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i], i == txt.len() - 1);
    endtask

    function automatic string rand_lexeme_body();
        string s;
        s = "";
        for (int i = $urandom_range(4); i > 0; i--)
            s = {s, string'(8'($urandom_range(32, 126) == 34 ? 8'h41 :
                             $urandom_range(32, 126)))};
        return s;
    endfunction

    // random lexeme, mostly well-formed
    function automatic string rand_lexeme();
        string kws [17] = '{"if", "else", "for", "while", "return", "class", "let",
                            "fn", "i8", "i16", "i32", "i64", "u8", "u16", "u32",
                            "u64", "bool"};
        string punct = "!@#%^&*()-+[]{}:;'\\|,.?<>`~";
        string s;
        int n;
        s = "";
        case ($urandom_range(11))
            0, 1: begin
                s = kws[$urandom_range(16)];
                if ($urandom_range(3) == 0) s = {s, "x"};
            end
            2: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(2) == 0 ? "_" :
                                       "a" + $urandom_range(25)))};
            end
            3: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(5) == 0 ? "." :
                                       "0" + $urandom_range(9)))};
            end
            4: s = {"\"", rand_lexeme_body(), "\""};
            5: s = ($urandom_range(1) != 0) ? "==" : "=";
            6: s = {"//", rand_lexeme_body(), "\n"};
            7: s = {"/*", rand_lexeme_body(), "*/"};
            8: s = string'(8'(punct[$urandom_range(punct.len() - 1)]));
            9: s = string'(8'($urandom_range(1, 255)));
            default: s = " ";
        endcase
        return s;
    endfunction

    task automatic random_text(input int budget);
        string txt;
        txt = "";
        while (txt.len() < budget) begin
            txt = {txt, rand_lexeme()};
            if ($urandom_range(2) == 0) txt = {txt, " "};
        end
        send_text(txt);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_tokens != 0 || u_chk.token_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed texts
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_text("if else for while return class let fn i8 i16");
        send_text("i32 i64 u8 u16 u32 u64 bool iff lets _x9 Ab");
        send_text("!@#%^&*()-+[]{}:;'\\|,.?<>`~ == = 12 3.4.5 .7");
        send_text("a/b/*x*/c//z\nd/*/ */ \t\r\013\014e");
        send_text({"\"str\" \"open", string'(8'hFF), string'(8'h80), string'(8'h01)});
        send_text("x=");
        send_text("y/");
        send_text("q//never ends");
        send_text("/*unterminated*");
        send_text("7");
        drain();

        // long hold-off at the receiver; the block must fill and stall
        hold_sink = 1'b1;
        fork
            send_text("a b c d e f g h ; ; ; ;");
            begin
                repeat (60) @(negedge aclk);
                hold_sink = 1'b0;
            end
        join
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 66 : 0;
            snk_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 27 : 0;
            for (int t = 0; t < 6; t++) random_text($urandom_range(4, 14));
            drain();   // sender waits for every expected token
        end

        $display("covered %0d bytes in %0d texts, %0d tokens checked",
                 bytes_sent, texts_sent, tokens_seen);
        if (fail_count == 0) begin
            $display("source_text_tokenizer regression: pass");
        end else begin
            $display("source_text_tokenizer regression: fail");
        end
        $finish;
    end
endmodule
